// ===== rtl/core/bapd_pkg.sv =====
`timescale 1ns / 1ps
package bapd_pkg;

  // Field widths.
  localparam int GyroW   = 16;
  localparam int AngleW  = 17;
  localparam int GainW   = 16;
  localparam int DeadW   = 16;
  localparam int DriveW  = 24;
  localparam int RateW   = 18;
  localparam int QuotW   = 17;
  localparam int CfgIdxW = 4;
  localparam int CfgDatW = 24;

  // Internal arithmetic widths.
  localparam int NumW    = 24;  // biased rate numerator, always positive
  localparam int RecipW  = 25;
  localparam int RecipSh = 31;
  localparam int AErrW   = 18;
  localparam int RErrW   = 19;
  localparam int DiffW   = 19;
  localparam int AccelW  = 24;
  localparam int PAngW   = GainW + AErrW;
  localparam int PAccW   = GainW + AccelW;
  localparam int PRateW  = GainW + RErrW;
  localparam int SumW    = 42;
  localparam int LawW    = SumW - 12;
  localparam int DzW     = 32;

  // The rate numerator gyro*160 + 41 is biased by 82*65536 so that it stays
  // positive; floor(m/82) comes from the reciprocal 2^31/82 rounded up, which
  // is exact over the whole numerator range.
  localparam logic [NumW-1:0]   NumBias = NumW'(82 * 65536 + 41);
  localparam logic [RecipW-1:0] Recip82 = RecipW'(26188825);
  localparam logic [RateW-1:0]  QuotBias = RateW'(65536);
  localparam logic signed [LawW-1:0] DeadKnee = LawW'(256);

  // Register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_KP        = 4'd0,
    REG_KI        = 4'd1,
    REG_KD        = 4'd2,
    REG_ANGLE_SET = 4'd3,
    REG_RATE_SET  = 4'd4,
    REG_DEAD      = 4'd5,
    REG_OUT_MAX   = 4'd6,
    REG_OUT_MIN   = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [GainW-1:0]  kp;
    logic signed [GainW-1:0]  ki;
    logic signed [GainW-1:0]  kd;
    logic signed [AngleW-1:0] angle_set;
    logic signed [AngleW-1:0] rate_set;
    logic        [DeadW-1:0]  dead;
    logic signed [DriveW-1:0] out_max;
    logic signed [DriveW-1:0] out_min;
  } ctrl_cfg_t;

endpackage

// ===== rtl/core/bapd_regs.sv =====
`timescale 1ns / 1ps
module bapd_regs
  import bapd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data,
  output ctrl_cfg_t          cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp        <= 16'sd10240;
      cfg.ki        <= -16'sd4096;
      cfg.kd        <= 16'sd4096;
      cfg.angle_set <= '0;
      cfg.rate_set  <= '0;
      cfg.dead      <= '0;
      cfg.out_max   <= 24'sd25600;
      cfg.out_min   <= -24'sd25600;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_KP:        cfg.kp        <= cfg_data[GainW-1:0];
        REG_KI:        cfg.ki        <= cfg_data[GainW-1:0];
        REG_KD:        cfg.kd        <= cfg_data[GainW-1:0];
        REG_ANGLE_SET: cfg.angle_set <= cfg_data[AngleW-1:0];
        REG_RATE_SET:  cfg.rate_set  <= cfg_data[AngleW-1:0];
        REG_DEAD:      cfg.dead      <= cfg_data[DeadW-1:0];
        REG_OUT_MAX:   cfg.out_max   <= cfg_data[DriveW-1:0];
        REG_OUT_MIN:   cfg.out_min   <= cfg_data[DriveW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/balance_angle_pd_motor_drive.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: gyro_raw, tilt_angle
// m_axis    out        m_axis_tvalid/tready      tdata: motor_drive; tuser: saturated
// cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One item per cycle sustained while m_axis takes results; each result passes
// the input register and the registers after the rate divide, the gain
// products, the sum and the dead zone and clamp. Reset is synchronous and clears
// all valid bits, the stored rate and the registers to their defaults. A stall
// on m_axis backs up only as far as the first empty stage; configuration
// writes are always taken.
module balance_angle_pd_motor_drive
  import bapd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [39:0]        s_axis_tdata,   // [15:0] gyro_raw, [32:16] tilt_angle
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // [23:0] motor_drive
  output logic               m_axis_tuser,   // [0] saturated
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  ctrl_cfg_t cfg;

  assign cfg_ready = 1'b1;

  bapd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Stage valid bits and the ready chain.
  logic v1, v2, v3, v4, vo;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  assign rdyo = !vo || m_axis_tready;
  assign rdy4 = !v4 || rdyo;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  // Stage 1: input register.
  logic signed [GyroW-1:0]  gyro1;
  logic signed [AngleW-1:0] tilt1;

  // Stage 2: rate quotient.
  logic [QuotW-1:0]         quot2;
  logic signed [AngleW-1:0] tilt2;

  // Stage 3: gain products.
  logic signed [PAngW-1:0]  p_ang;
  logic signed [PAccW-1:0]  p_acc;
  logic signed [PRateW-1:0] p_rate;
  logic signed [RateW-1:0]  previous_rate;

  // Stage 4: control law before dead zone.
  logic signed [LawW-1:0]   law;

  // Output register.
  logic signed [DriveW-1:0] drive;
  logic                     sat;

  // Rate from the raw gyro word: floor((gyro*160 + 41) / 82).
  logic signed [NumW:0]            g_ext;
  logic [NumW-1:0]                 num;
  logic [NumW+RecipW-1:0]          quot_prod;

  assign g_ext     = (NumW+1)'(gyro1);
  assign num       = NumW'((g_ext <<< 7) + (g_ext <<< 5) + $signed({1'b0, NumBias}));
  assign quot_prod = num * Recip82;

  // Rate error, angle error and acceleration.
  logic signed [RateW-1:0]  rate;
  logic signed [DiffW-1:0]  diff;
  logic signed [AccelW-1:0] accel;
  logic signed [AErrW-1:0]  a_err;
  logic signed [RErrW-1:0]  r_err;

  assign rate  = $signed(RateW'({1'b0, quot2}) - QuotBias);
  assign diff  = DiffW'(rate) - DiffW'(previous_rate);
  assign accel = (AccelW'(diff) <<< 4) + (AccelW'(diff) <<< 2);
  assign a_err = AErrW'(cfg.angle_set) - AErrW'(tilt2);
  assign r_err = RErrW'(cfg.rate_set) - RErrW'(rate);

  logic signed [SumW-1:0] sum;
  assign sum = SumW'(p_ang) + SumW'(p_acc) + SumW'(p_rate);

  // Dead zone and clamp. The lower limit is applied last, so inverted limits
  // end at out_min.
  logic signed [DzW-1:0] dz;
  logic signed [DzW-1:0] dmax, dmin;
  logic signed [DzW-1:0] after_max;
  logic                  hit_max, hit_min;
  logic signed [DriveW-1:0] drive_next;
  logic                  sat_next;

  always_comb begin
    if (law > DeadKnee) begin
      dz = DzW'(law) + $signed({{(DzW-DeadW){1'b0}}, cfg.dead});
    end else if (law < -DeadKnee) begin
      dz = DzW'(law) - $signed({{(DzW-DeadW){1'b0}}, cfg.dead});
    end else begin
      dz = DzW'(law);
    end
    dmax      = DzW'(cfg.out_max);
    dmin      = DzW'(cfg.out_min);
    hit_max   = dz > dmax;
    after_max = hit_max ? dmax : dz;
    hit_min   = after_max < dmin;
    drive_next = hit_min ? cfg.out_min : after_max[DriveW-1:0];
    sat_next   = hit_max || hit_min;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
      previous_rate <= '0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdyo) vo <= v4;
      // The stored rate follows each item as it leaves the rate stage.
      if (rdy3 && v2) previous_rate <= rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      gyro1 <= s_axis_tdata[15:0];
      tilt1 <= s_axis_tdata[32:16];
    end
    if (rdy2) begin
      quot2 <= quot_prod[RecipSh +: QuotW];
      tilt2 <= tilt1;
    end
    if (rdy3) begin
      p_ang  <= PAngW'(cfg.kp) * PAngW'(a_err);
      p_acc  <= PAccW'(cfg.ki) * PAccW'(accel);
      p_rate <= PRateW'(cfg.kd) * PRateW'(r_err);
    end
    if (rdy4) begin
      law <= sum[SumW-1:12];
    end
    if (rdyo) begin
      drive <= drive_next;
      sat   <= sat_next;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = drive;
  assign m_axis_tuser  = sat;

endmodule

// ===== test/balance_angle_pd_motor_drive_tb.sv =====
`timescale 1ns / 1ps
module balance_angle_pd_motor_drive_tb;
  import bapd_pkg::*;

  localparam int PipeDepth  = 5;
  localparam int StallLimit = 2000;
  localparam logic [CfgIdxW-1:0] UnusedIdx = 4'd12;

  typedef struct {
    logic signed [GyroW-1:0]  gyro;
    logic signed [AngleW-1:0] tilt;
  } sample_t;

  typedef struct {
    logic [DriveW-1:0] drive;
    logic              sat;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [39:0]        s_axis_tdata = '0;   // [15:0] gyro_raw, [32:16] tilt_angle
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;        // [23:0] motor_drive
  logic               m_axis_tuser;        // [0] saturated
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDatW-1:0] cfg_data = '0;

  balance_angle_pd_motor_drive dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Controller copy: gains, setpoints, limits and the stored rate.
  logic signed [GainW-1:0]  kp_gain, ki_gain, kd_gain;
  logic signed [AngleW-1:0] angle_set, rate_set;
  logic        [DeadW-1:0]  dead_offset;
  logic signed [DriveW-1:0] drive_max, drive_min;
  longint                   prev_rate;

  sample_t       sample_queue[$];
  drive_result_t pending_drives[$];

  int  src_idle_pct = 10;
  int  sink_idle_pct = 68;
  int  last_gyro = 0;
  int  idle_cycles = 0;
  int  n_samples = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_saturated = 0;
  logic item_taken = 1'b0;

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDatW-1:0] data);
    case (idx)
      REG_KP:        kp_gain = data[GainW-1:0];
      REG_KI:        ki_gain = data[GainW-1:0];
      REG_KD:        kd_gain = data[GainW-1:0];
      REG_ANGLE_SET: angle_set = data[AngleW-1:0];
      REG_RATE_SET:  rate_set = data[AngleW-1:0];
      REG_DEAD:      dead_offset = data[DeadW-1:0];
      REG_OUT_MAX:   drive_max = data[DriveW-1:0];
      REG_OUT_MIN:   drive_min = data[DriveW-1:0];
      default: ;
    endcase
  endfunction

  function automatic drive_result_t predict_drive(input logic signed [GyroW-1:0] gyro,
                                                  input logic signed [AngleW-1:0] tilt);
    drive_result_t res;
    longint num, rate, accel, sum, v;
    num = longint'(gyro) * 160 + 41;
    rate = num / 82;
    if (num % 82 != 0 && num < 0) begin
      rate = rate - 1;
    end
    accel = 20 * (rate - prev_rate);
    sum = longint'(kp_gain) * (longint'(angle_set) - longint'(tilt))
        + longint'(ki_gain) * accel
        + longint'(kd_gain) * (longint'(rate_set) - rate);
    v = sum >>> 12;
    if (v > 256) begin
      v = v + longint'(dead_offset);
    end else if (v < -256) begin
      v = v - longint'(dead_offset);
    end
    res.sat = 1'b0;
    if (v > longint'(drive_max)) begin
      v = drive_max;
      res.sat = 1'b1;
    end
    if (v < longint'(drive_min)) begin
      v = drive_min;
      res.sat = 1'b1;
    end
    res.drive = v[DriveW-1:0];
    prev_rate = rate;
    return res;
  endfunction

  // Sender side and sink ready: a new item goes out only once the previous one was taken.
  always @(negedge clk) begin
    sample_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || item_taken) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = sample_queue.pop_front();
          s_axis_tdata  <= {7'd0, nxt.tilt, nxt.gyro};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk) begin
    drive_result_t want;
    logic s_acc, m_acc;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      s_acc = s_axis_tvalid && s_axis_tready;
      m_acc = m_axis_tvalid && m_axis_tready;
      item_taken <= s_acc;
      if (m_acc) begin
        n_results++;
        if (pending_drives.size() == 0) begin
          $error("unexpected result: motor_drive %0d saturated %0d",
                 $signed(m_axis_tdata), m_axis_tuser);
          n_errors++;
        end else begin
          want = pending_drives.pop_front();
          if (want.sat) n_saturated++;
          if (m_axis_tdata !== want.drive) begin
            $error("motor_drive mismatch: expected %0d, actual %0d",
                   $signed(want.drive), $signed(m_axis_tdata));
            n_errors++;
          end
          if (m_axis_tuser !== want.sat) begin
            $error("saturated mismatch: expected %0d, actual %0d", want.sat, m_axis_tuser);
            n_errors++;
          end
        end
      end
      if (s_acc) begin
        pending_drives.push_back(predict_drive(s_axis_tdata[15:0], s_axis_tdata[32:16]));
        n_samples++;
      end
      if (s_acc || m_acc || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("Timeout: no item moved for %0d cycles", StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper bits beyond each register's width carry random junk.
  task automatic load_config(input int kp, input int ki, input int kd, input int aset,
                             input int rset, input int dead, input int omax, input int omin);
    write_reg(REG_KP,        {8'($urandom), 16'(kp)});
    write_reg(REG_KI,        {8'($urandom), 16'(ki)});
    write_reg(REG_KD,        {8'($urandom), 16'(kd)});
    write_reg(REG_ANGLE_SET, {7'($urandom), 17'(aset)});
    write_reg(REG_RATE_SET,  {7'($urandom), 17'(rset)});
    write_reg(REG_DEAD,      {8'($urandom), 16'(dead)});
    write_reg(REG_OUT_MAX,   24'(omax));
    write_reg(REG_OUT_MIN,   24'(omin));
  endtask

  task automatic random_config();
    load_config(int'($urandom_range(16383)) - 8192, int'($urandom_range(1023)) - 512,
                int'($urandom_range(16383)) - 8192, int'($urandom_range(92160)) - 46080,
                int'($urandom_range(131071)) - 65536, int'($urandom_range(2000)),
                int'($urandom_range(40000, 300)), -int'($urandom_range(40000, 300)));
  endtask

  task automatic push_sample(input int g, input int t);
    sample_t s;
    s.gyro = GyroW'(g);
    s.tilt = AngleW'(t);
    sample_queue.push_back(s);
    last_gyro = int'(s.gyro);
  endtask

  task automatic push_random(input int count);
    int g, t;
    repeat (count) begin
      g = int'($urandom_range(65535)) - 32768;
      t = int'($urandom_range(92160)) - 46080;
      case ($urandom_range(9))
        4, 5: begin
          g = int'($urandom_range(600)) - 300;
          t = int'($urandom_range(1200)) - 600;
        end
        6: g = last_gyro + int'($urandom_range(40)) - 20;
        7: begin
          g = last_gyro;
          t = int'($urandom_range(1200)) - 600;
        end
        8: t = int'($urandom_range(131071)) - 65536;
        9: begin
          g = $urandom_range(1) ? 32767 : -32768;
          t = $urandom_range(1) ? 46080 : -46080;
        end
        default: ;
      endcase
      push_sample(g, t);
    end
  endtask

  // Nothing left to send or to receive, then a drain margin sized from PipeDepth.
  task automatic wait_idle();
    while (sample_queue.size() != 0 || s_axis_tvalid || pending_drives.size() != 0)
      @(negedge clk);
    repeat (PipeDepth + 2) @(negedge clk);
  endtask

  initial begin
    kp_gain = 16'sd10240;
    ki_gain = -16'sd4096;
    kd_gain = 16'sd4096;
    angle_set = '0;
    rate_set = '0;
    dead_offset = '0;
    drive_max = 24'sd25600;
    drive_min = -24'sd25600;
    prev_rate = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: gyro and tilt extremes, out of range tilt, small steps.
    push_sample(0, 0);
    push_sample(32767, 0);
    push_sample(-32768, 0);
    push_sample(-32768, -46080);
    push_sample(32767, 46080);
    push_sample(1, -65536);
    push_sample(-1, 65535);
    push_sample(0, -1);
    push_sample(41, 1);
    push_sample(-41, 100);
    wait_idle();

    // Unity angle gain only, so the law before the dead zone equals minus the tilt:
    // dead band edges and both clamp edges.
    load_config(4096, 0, 0, 0, 0, 1000, 2000, -2000);
    push_sample(0, -256);
    push_sample(0, -257);
    push_sample(0, 256);
    push_sample(0, 257);
    push_sample(0, 0);
    push_sample(0, -1000);
    push_sample(0, -1001);
    push_sample(0, 1000);
    push_sample(0, 1001);
    push_sample(0, -5000);
    push_sample(0, 5000);
    push_sample(0, -46080);
    wait_idle();

    random_config();
    write_reg(UnusedIdx, 24'($urandom));
    push_random(180);
    wait_idle();

    src_idle_pct = 68;
    sink_idle_pct = 10;
    load_config(-32768, 32767, -32768, 46080, -65536, 65535, 8388607, -8388608);
    push_random(90);
    wait_idle();
    // Inverted limits: every drive ends at the lower limit.
    load_config(int'($urandom_range(16383)) - 8192, 100, 4096, 0, 0, 50, -100, 100);
    push_random(90);
    wait_idle();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    load_config(32767, -32768, 32767, -46080, 65535, 0, 8388607, -8388608);
    push_random(95);
    wait_idle();
    random_config();
    push_random(95);
    wait_idle();

    $display("Checked %0d drive results from %0d samples (%0d clamped) across seven",
             n_results, n_samples, n_saturated);
    $display("register settings, including extreme gains and inverted limits.");
    if (n_errors == 0 && pending_drives.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bapd_pkg.sv
rtl/core/bapd_regs.sv
rtl/core/balance_angle_pd_motor_drive.sv
test/balance_angle_pd_motor_drive_tb.sv
